// File: rtl/ergs_pkg.sv
// Shared types and constants for the Euclidean rhythm gate sequencer.
// No dependencies; imported by the core and its checker.
`default_nettype none

package ergs_pkg;

	// Width of each configuration register and of the config data port
	localparam int CFG_W = 7;

	// Width of the configuration register index
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_W-1:0] LEN_RESET = 7'd32;
	localparam logic [CFG_W-1:0] HITS_RESET = 7'd12;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LENGTH = 1'b0,
		REG_HIT_COUNT      = 1'b1
	} cfg_reg_t;

endpackage

`default_nettype wire

// File: rtl/euclidean_rhythm_gate_sequencer_core.sv
// Euclidean rhythm gate sequencer core: tick processing, step accumulator,
// output skid buffer. Depends on ergs_pkg.
`default_nettype none

// One item is one tick of thresholded clock and reset levels, and every item
// gives one gate item. Items are accepted at one per cycle while the skid
// entry is empty and no rebuild runs: the tick logic sits between the input
// handshake and a two-entry output buffer, so the next item is taken while an
// earlier gate item still waits. The pattern bit is found without division: an
// accumulator holds ((step+1)*hits) mod length and moves by one add-and-wrap
// per step. After each configuration write it is rebuilt by the same unit,
// one add per cycle, which holds in_ready low until the adds reach step_index.
module euclidean_rhythm_gate_sequencer_core
	import ergs_pkg::*;
#(
	parameter int MAX_STEPS = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output      logic                 in_ready,
	input  wire logic                 clock_level,
	input  wire logic                 reset_level,
	output      logic                 out_valid,
	input  wire logic                 out_ready,
	output      logic                 gate,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	localparam int SW = $clog2(MAX_STEPS);
	localparam int CmpW = ((SW > CFG_W) ? SW : CFG_W) + 1;

	logic [CFG_W-1:0] len_cfg_q;
	logic [CFG_W-1:0] hits_q;
	logic [SW-1:0]    step_q;
	logic [CFG_W-1:0] acc_q;
	logic             last_clk_q;
	logic             last_rst_q;
	logic             gate_q;

	logic             busy_q;
	logic [SW-1:0]    cnt_q;

	logic             out_valid_q;
	logic             out_gate_q;
	logic             skid_valid_q;
	logic             skid_gate_q;

	logic [CFG_W-1:0] len;
	logic             in_fire;
	logic             rst_chg;
	logic             rise;
	logic             fall;
	logic             wrap;
	logic [SW-1:0]    step_b;
	logic [CFG_W-1:0] acc_b;
	logic [SW-1:0]    step_n;
	logic [CFG_W-1:0] acc_n;
	logic             gate_n;
	logic             all_hits;

	// Add hits to an accumulator held below len and wrap once
	function automatic logic [CFG_W-1:0] add_wrap(
		input logic [CFG_W-1:0] a,
		input logic [CFG_W-1:0] h,
		input logic [CFG_W-1:0] l
	);
		logic [CFG_W:0] sum;
		sum = {1'b0, a} + {1'b0, h};
		if (sum >= {1'b0, l}) begin
			sum = sum - {1'b0, l};
		end
		return sum[CFG_W-1:0];
	endfunction

	// Effective length: zero reads as one, clamp at MAX_STEPS
	always_comb begin
		if (len_cfg_q == '0) begin
			len = CFG_W'(1);
		end else if (int'(len_cfg_q) > MAX_STEPS) begin
			len = CFG_W'(MAX_STEPS);
		end else begin
			len = len_cfg_q;
		end
	end

	assign in_ready = !busy_q && !skid_valid_q && !cfg_we;
	assign in_fire  = in_valid && in_ready;
	assign all_hits = hits_q >= len;

	always_comb begin
		rst_chg = reset_level != last_rst_q;
		rise    = clock_level && !last_clk_q;
		fall    = !clock_level && last_clk_q;
		step_b  = rst_chg ? '0 : step_q;
		acc_b   = rst_chg ? hits_q : acc_q;
		wrap    = CmpW'(step_b) >= (CmpW'(len) - CmpW'(1));
		step_n  = step_b;
		acc_n   = acc_b;
		gate_n  = gate_q;
		if (rise) begin
			if (wrap) begin
				step_n = '0;
				acc_n  = hits_q;
			end else begin
				step_n = step_b + SW'(1);
				acc_n  = add_wrap(acc_b, hits_q, len);
			end
			// A bucket overflow shows as a wrapped remainder below hits
			gate_n = all_hits || (acc_n < hits_q);
		end else if (fall) begin
			gate_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_cfg_q    <= LEN_RESET;
			hits_q       <= HITS_RESET;
			step_q       <= '0;
			acc_q        <= HITS_RESET;
			last_clk_q   <= 1'b0;
			last_rst_q   <= 1'b0;
			gate_q       <= 1'b0;
			busy_q       <= 1'b0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_PATTERN_LENGTH: len_cfg_q <= cfg_data;
					REG_HIT_COUNT:      hits_q <= cfg_data;
					default:            ;
				endcase
				// Rebuild the accumulator against the new settings
				busy_q <= 1'b1;
				cnt_q  <= '0;
				acc_q  <= '0;
			end else if (busy_q) begin
				acc_q <= add_wrap(acc_q, hits_q, len);
				if (cnt_q == step_q) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + SW'(1);
				end
			end else if (in_fire) begin
				step_q     <= step_n;
				acc_q      <= acc_n;
				last_clk_q <= clock_level;
				last_rst_q <= reset_level;
				gate_q     <= gate_n;
			end

			// Output register with a skid stage behind it
			if (skid_valid_q) begin
				if (out_ready) begin
					skid_valid_q <= 1'b0;
				end
			end else if (in_fire) begin
				if (!out_valid_q || out_ready) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload side of the output buffer
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_ready) begin
				out_gate_q <= skid_gate_q;
			end
		end else if (in_fire) begin
			if (!out_valid_q || out_ready) begin
				out_gate_q <= gate_n;
			end else begin
				skid_gate_q <= gate_n;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign gate      = out_gate_q;

endmodule

`default_nettype wire

// File: rtl/ergs_checker.sv
// Port-level checker for the Euclidean rhythm gate sequencer core, with its
// bind statement. Depends on ergs_pkg.
`default_nettype none

module ergs_checker
	import ergs_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_ready,
	input wire logic                 clock_level,
	input wire logic                 reset_level,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire logic                 gate,
	input wire logic                 cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_W-1:0]     cfg_data
);

	// Hold input off while a config write lands and during the rebuild
	a_cfg_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !in_ready ##1 !in_ready)
		else $error("item accepted around a configuration write");

	// A gate item waiting for the consumer must hold
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(gate))
		else $error("gate item dropped or changed while stalled");

	// With the clock low the gate is always low
	a_low_clock: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !clock_level && (!out_valid || out_ready)
		|=> out_valid && !gate)
		else $error("gate high for a tick with the clock low");

	// Every accepted tick leaves a gate item pending on the next cycle
	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted tick gave no gate item");

endmodule

bind euclidean_rhythm_gate_sequencer_core ergs_checker u_ergs_checker (.*);

`default_nettype wire

// File: tb/tb.sv
// Self-checking bench for euclidean_rhythm_gate_sequencer_core: random ticks, both-side stalls.
// Expected gate levels come from a bench-side sequencer model.
// Depends on ergs_pkg and the core RTL.
module tb;
	import ergs_pkg::*;

	localparam int MAX_STEPS = 64;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic clock_level = 1'b0;
	logic reset_level = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic gate;
	logic cfg_we = 1'b0;
	cfg_reg_t cfg_index = REG_PATTERN_LENGTH;
	logic [CFG_W-1:0] cfg_data = '0;

	euclidean_rhythm_gate_sequencer_core #(.MAX_STEPS(MAX_STEPS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.clock_level(clock_level),
		.reset_level(reset_level),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.gate(gate),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Sequencer model state
	logic [CFG_W-1:0] seq_len = LEN_RESET;
	logic [CFG_W-1:0] seq_hits = HITS_RESET;
	int unsigned seq_step = 0;
	bit seq_last_clk = 1'b0;
	bit seq_last_rst = 1'b0;
	bit seq_gate = 1'b0;

	bit gate_expect_q[$];
	bit gate_want;
	int unsigned gate_errors = 0;
	int unsigned gate_seen = 0;
	int unsigned tick_count = 0;

	bit tx_idle = 1'b0;
	bit rx_idle = 1'b0;
	int unsigned rx_wait = 0;
	int unsigned hold_req = 0;
	bit last_clk_sent = 1'b0;
	bit last_rst_sent = 1'b0;

	function automatic int unsigned pick_gap();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic int unsigned pattern_steps();
		int unsigned n;
		n = seq_len;
		if (n == 0)
			n = 1;
		if (n > MAX_STEPS)
			n = MAX_STEPS;
		return n;
	endfunction

	// Bucket rule: a hit wherever floor(i*hits/len) steps up
	function automatic bit euclid_hit(int unsigned i, int unsigned n);
		int unsigned h;
		h = seq_hits;
		if (h >= n)
			return 1'b1;
		return ((i + 1) * h) / n > (i * h) / n;
	endfunction

	function automatic bit advance_tick(bit c, bit r);
		int unsigned n;
		n = pattern_steps();
		// reset level first, then the clock
		if (r != seq_last_rst) begin
			seq_step = 0;
			seq_last_rst = r;
		end
		if (c != seq_last_clk) begin
			if (c) begin
				if (seq_step >= n - 1)
					seq_step = 0;
				else
					seq_step++;
				seq_gate = euclid_hit(seq_step, n);
			end else begin
				seq_gate = 1'b0;
			end
			seq_last_clk = c;
		end
		return seq_gate;
	endfunction

	// Predict on accepted ticks, compare on accepted gate items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_len = LEN_RESET;
			seq_hits = HITS_RESET;
			seq_step = 0;
			seq_last_clk = 1'b0;
			seq_last_rst = 1'b0;
			seq_gate = 1'b0;
			gate_expect_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PATTERN_LENGTH: seq_len = cfg_data;
					REG_HIT_COUNT:      seq_hits = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				gate_expect_q.push_back(advance_tick(clock_level, reset_level));
			if (out_valid && out_ready) begin
				if (gate_expect_q.size() == 0) begin
					$display("%0t: unexpected gate item, expected none, actual %0b",
						$time, gate);
					gate_errors++;
				end else begin
					gate_want = gate_expect_q.pop_front();
					if (gate !== gate_want) begin
						$display("%0t: gate mismatch, expected %0b, actual %0b",
							$time, gate_want, gate);
						gate_errors++;
					end
				end
				gate_seen++;
			end
		end
	end

	// Receiver: random stalls, plus a long hold when requested
	always @(posedge clk) begin
		if (rx_wait != 0) begin
			rx_wait <= rx_wait - 1;
			out_ready <= (rx_wait == 1);
		end else if (hold_req != 0) begin
			rx_wait <= hold_req;
			hold_req <= 0;
			out_ready <= 1'b0;
		end else if (rx_idle && $urandom_range(0, 3) == 0) begin
			rx_wait <= pick_gap();
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic send_tick(input bit c, input bit r);
		int unsigned gap;
		gap = (tx_idle && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		clock_level <= c;
		reset_level <= r;
		do @(posedge clk); while (!in_ready);
		tick_count++;
		last_clk_sent = c;
		last_rst_sent = r;
	endtask

	// Drop valid and wait until every gate item has come back
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (gate_seen != tick_count);
	endtask

	task automatic write_reg(input cfg_reg_t which, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= which;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		// hold off until the accumulator rebuild is surely over
		repeat (MAX_STEPS + 4) @(posedge clk);
	endtask

	task automatic program_pattern(input int unsigned len, input int unsigned hits);
		settle();
		write_reg(REG_PATTERN_LENGTH, len[CFG_W-1:0]);
		write_reg(REG_HIT_COUNT, hits[CFG_W-1:0]);
	endtask

	task automatic clock_pulse();
		send_tick(1'b1, last_rst_sent);
		send_tick(1'b0, last_rst_sent);
	endtask

	task automatic test_clock_and_reset_edges();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b0);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b0);
		// reset change with the clock held high, then again with it low: step 0 then 1
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b0);
		settle();
	endtask

	task automatic test_length_extremes();
		program_pattern(0, 1);
		clock_pulse();
		program_pattern(127, 64);
		clock_pulse();
		program_pattern(1, 0);
		clock_pulse();
		program_pattern(127, 127);
		clock_pulse();
		program_pattern(5, 9);
		clock_pulse();
		settle();
	endtask

	// Mostly clean clock toggles with rare reset flips, some noise ticks
	task automatic run_random_phase(input int unsigned len, input int unsigned hits,
			input int unsigned n);
		bit c;
		bit r;
		program_pattern(len, hits);
		tx_idle = $urandom_range(0, 3) != 0;
		rx_idle = $urandom_range(0, 3) != 0;
		repeat (n) begin
			if ($urandom_range(0, 9) < 8) begin
				c = ~last_clk_sent;
				r = ($urandom_range(0, 49) == 0) ? ~last_rst_sent : last_rst_sent;
			end else begin
				c = 1'($urandom_range(0, 1));
				r = ($urandom_range(0, 3) == 0) ? ~last_rst_sent : last_rst_sent;
			end
			send_tick(c, r);
		end
		settle();
	endtask

	task automatic test_random_patterns();
		int unsigned len;
		int unsigned hits;
		run_random_phase(1, 0, 30);
		run_random_phase(2, 1, 30);
		run_random_phase(0, 0, 30);
		run_random_phase(5, 7, 30);
		// long patterns back to back so the step walks past a full wrap
		run_random_phase(64, 63, 70);
		run_random_phase(64, 0, 70);
		run_random_phase(127, 127, 70);
		run_random_phase(65, 3, 70);
		run_random_phase(64, 37, 50);
		// shrink the length under a step that is likely far along
		run_random_phase(3, 2, 30);
		repeat (4) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64);
			hits = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
				: $urandom_range(0, len + 1);
			run_random_phase(len, hits, (len >= 32) ? 60 : 30);
		end
	endtask

	task automatic test_output_backpressure();
		program_pattern($urandom_range(1, 64), $urandom_range(0, 64));
		tx_idle = 1'b0;
		hold_req <= 150;
		repeat (30) send_tick(~last_clk_sent, last_rst_sent);
		settle();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_clock_and_reset_edges();
		test_length_extremes();
		test_random_patterns();
		test_output_backpressure();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		settle();
		repeat (60) @(posedge clk);
		if (gate_expect_q.size() != 0) begin
			$display("%0t: %0d gate items never arrived", $time, gate_expect_q.size());
			gate_errors++;
		end
		if (gate_errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
